[hdl/ipv4p_pkg.sv]
// types and constants shared by the dotted address parser modules
// no dependencies
`default_nettype none

package ipv4p_pkg;

	// ascii codes the classifier looks at
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;

	// masks for the widths that the last part may take
	localparam logic [31:0] MASK_24 = 32'h00ff_ffff;
	localparam logic [31:0] MASK_16 = 32'h0000_ffff;
	localparam logic [31:0] MASK_8  = 32'h0000_00ff;

	typedef enum logic [2:0] {
		K_END,
		K_DEC,
		K_HEX,
		K_X,
		K_DOT,
		K_SPACE,
		K_OTHER
	} char_kind_t;

	// one classified byte
	typedef struct packed {
		char_kind_t  kind;
		logic [3:0]  value;
	} char_class_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic        valid;
		char_class_t cls;
	} queue_head_t;

endpackage

`default_nettype wire

[hdl/ipv4p_char_if.sv]
// byte channel carrying one character of the address string
// no dependencies
`default_nettype none

interface ipv4p_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

[hdl/ipv4p_res_if.sv]
// result channel carrying the parse flag and the address
// no dependencies
`default_nettype none

interface ipv4p_res_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] address;

	modport source (output valid, output ok, output address, input ready);
	modport sink (input valid, input ok, input address, output ready);
endinterface

`default_nettype wire

[hdl/ipv4_dotted_address_parser_unit.sv]
// top level of the dotted address parser: front classifier, byte queue, back parser
// depends on ipv4p_pkg, ipv4p_char_if, ipv4p_res_if, ipv4p_front, ipv4p_queue, ipv4p_back
//
// usage
//   chars: one word per byte of the address string, zero byte closes the string
//   results: one word per string, ok flag plus 32-bit address in host order
//     (first part in the top byte, zero when ok is low)
//   the front classifies each byte as it arrives and drops it into a short queue;
//   the back runs the parse state machine one byte per cycle out of that queue
//   throughput: one byte per cycle sustained; chars.ready only drops when the
//     queue is full, which happens only while a finished result sits unread
//   result path: a zero byte, once its word is accepted, is written into the
//     queue, then parsed from the queue head into the result register
//   stall: while results.ready is low, the back keeps parsing the next string
//     and only a second zero byte waits at the queue head; once the queue fills,
//     chars.ready goes low
//   reset: arst_n clears the queue, the parser state and the result register;
//     the block takes words on the first cycle after reset
`default_nettype none

module ipv4_dotted_address_parser_unit
	import ipv4p_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ipv4p_char_if.sink    chars,
	ipv4p_res_if.source   results
);

	char_class_t in_cls;
	queue_head_t head;
	logic        queue_full;
	logic        push;
	logic        pop;

	// word accepted whenever the queue has room
	assign chars.ready = !queue_full;
	assign push        = chars.valid && !queue_full;

	// byte classification, pure logic in front of the queue
	ipv4p_front u_front (
		.char_code (chars.char_code),
		.cls       (in_cls)
	);

	// decouples arrival from parsing so either side may stall alone
	ipv4p_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (in_cls),
		.full     (queue_full),
		.pop      (pop),
		.head     (head)
	);

	// parse state machine and result register
	ipv4p_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire

[hdl/ipv4p_front.sv]
// front end: sorts each incoming byte into a character class with a digit value
// depends on ipv4p_pkg
`default_nettype none

module ipv4p_front
	import ipv4p_pkg::*;
(
	input  wire logic [7:0] char_code,
	output char_class_t     cls
);

	logic is_dec;
	logic is_hex;
	logic is_space;

	assign is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_hex   = ((char_code >= CH_LC_A) && (char_code <= CH_LC_F)) ||
	                  ((char_code >= CH_UC_A) && (char_code <= CH_UC_F));
	assign is_space = (char_code == CH_SPACE) ||
	                  ((char_code >= CH_TAB) && (char_code <= CH_CR));

	always_comb begin
		cls.value = char_code[3:0];
		if (char_code == CH_NUL) begin
			cls.kind = K_END;
		end else if (is_dec) begin
			cls.kind = K_DEC;
		end else if (is_hex) begin
			// a..f and A..F both have 1..6 in the low nibble
			cls.kind  = K_HEX;
			cls.value = char_code[3:0] + 4'd9;
		end else if ((char_code == CH_LC_X) || (char_code == CH_UC_X)) begin
			cls.kind = K_X;
		end else if (char_code == CH_DOT) begin
			cls.kind = K_DOT;
		end else if (is_space) begin
			cls.kind = K_SPACE;
		end else begin
			cls.kind = K_OTHER;
		end
	end

endmodule

`default_nettype wire

[hdl/ipv4p_queue.sv]
// short queue of classified bytes between front and back end
// depends on ipv4p_pkg
`default_nettype none

module ipv4p_queue
	import ipv4p_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire char_class_t push_cls,
	output logic             full,
	input  wire logic        pop,
	output queue_head_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	char_class_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

	// a pop never meets an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

endmodule

`default_nettype wire

[hdl/ipv4p_back.sv]
// back end: parse state machine over classified bytes plus the result register
// depends on ipv4p_pkg and ipv4p_res_if
`default_nettype none

module ipv4p_back
	import ipv4p_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire queue_head_t head,
	output logic             pop,
	ipv4p_res_if.source      results
);

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE,
		PH_FAIL
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC,
		RX_OCT,
		RX_HEX
	} radix_t;

	phase_t      phase_q, phase_d;
	radix_t      radix_q, radix_d;
	logic [31:0] part_q, part_d;
	logic [1:0]  parts_done_q, parts_done_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] second_q, second_d;
	logic [23:0] third_q, third_d;
	logic [32:0] held_q, held_d;
	logic        res_valid_q, res_valid_d;
	logic [32:0] res_q, res_d;

	logic [31:0] part_scaled;
	logic [31:0] part_acc;
	logic        is_end;

	// bit 32 ok, low bits the address; zero when the last part is too wide
	function automatic logic [32:0] finish(input logic [31:0] pv, input logic [1:0] n,
		input logic [7:0] f1, input logic [15:0] f2, input logic [23:0] f3);
		logic        fits;
		logic [31:0] v;
		case (n)
			2'd1:    fits = ((pv & ~MASK_24) == '0);
			2'd2:    fits = ((pv & ~MASK_16) == '0);
			2'd3:    fits = ((pv & ~MASK_8) == '0);
			default: fits = 1'b1;
		endcase
		v = pv;
		if (n >= 2'd1) v = v | {f1, 24'd0};
		if (n >= 2'd2) v = v | {f2, 16'd0};
		if (n >= 2'd3) v = v | {f3, 8'd0};
		return fits ? {1'b1, v} : 33'd0;
	endfunction

	assign is_end = (head.cls.kind == K_END);
	// an end byte waits while the result register is still full
	assign pop    = head.valid && !(is_end && res_valid_q && !results.ready);

	always_comb begin
		case (radix_q)
			RX_HEX:  part_scaled = {part_q[27:0], 4'd0};
			RX_OCT:  part_scaled = {part_q[28:0], 3'd0};
			default: part_scaled = {part_q[28:0], 3'd0} + {part_q[30:0], 1'b0};
		endcase
		part_acc = part_scaled + {28'd0, head.cls.value};
	end

	always_comb begin
		phase_d      = phase_q;
		radix_d      = radix_q;
		part_d       = part_q;
		parts_done_d = parts_done_q;
		first_d      = first_q;
		second_d     = second_q;
		third_d      = third_q;
		held_d       = held_q;
		res_valid_d  = res_valid_q && !results.ready;
		res_d        = res_q;
		if (pop) begin
			if (is_end) begin
				res_valid_d = 1'b1;
				case (phase_q)
					PH_ZERO, PH_DIGITS: res_d = finish(part_q, parts_done_q,
						first_q, second_q, third_q);
					PH_DONE:            res_d = held_q;
					default:            res_d = '0;
				endcase
				phase_d      = PH_START;
				radix_d      = RX_DEC;
				part_d       = '0;
				parts_done_d = '0;
				first_d      = '0;
				second_d     = '0;
				third_d      = '0;
				held_d       = '0;
			end else begin
				case (phase_q)
					PH_START: begin
						if (head.cls.kind != K_DEC) begin
							phase_d = PH_FAIL;
						end else if (head.cls.value == 4'd0) begin
							part_d  = '0;
							radix_d = RX_OCT;
							phase_d = PH_ZERO;
						end else begin
							part_d  = {28'd0, head.cls.value};
							radix_d = RX_DEC;
							phase_d = PH_DIGITS;
						end
					end
					PH_ZERO, PH_DIGITS: begin
						phase_d = PH_DIGITS;
						case (head.cls.kind)
							K_X: begin
								if (phase_q == PH_ZERO) begin
									radix_d = RX_HEX;
								end else begin
									phase_d = PH_FAIL;
								end
							end
							K_DEC: part_d = part_acc;
							K_HEX: begin
								if (radix_q == RX_HEX) begin
									part_d = part_acc;
								end else begin
									phase_d = PH_FAIL;
								end
							end
							K_DOT: begin
								if (parts_done_q == 2'd3) begin
									phase_d = PH_FAIL;
								end else begin
									case (parts_done_q)
										2'd0:    first_d  = part_q[7:0];
										2'd1:    second_d = part_q[15:0];
										default: third_d  = part_q[23:0];
									endcase
									parts_done_d = parts_done_q + 2'd1;
									part_d       = '0;
									radix_d      = RX_DEC;
									phase_d      = PH_START;
								end
							end
							K_SPACE: begin
								held_d  = finish(part_q, parts_done_q,
									first_q, second_q, third_q);
								phase_d = PH_DONE;
							end
							default: phase_d = PH_FAIL;
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			radix_q      <= RX_DEC;
			part_q       <= '0;
			parts_done_q <= '0;
			first_q      <= '0;
			second_q     <= '0;
			third_q      <= '0;
			held_q       <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			phase_q      <= phase_d;
			radix_q      <= radix_d;
			part_q       <= part_d;
			parts_done_q <= parts_done_d;
			first_q      <= first_d;
			second_q     <= second_d;
			third_q      <= third_d;
			held_q       <= held_d;
			res_valid_q  <= res_valid_d;
			res_q        <= res_d;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.ok      = res_q[32];
	assign results.address = res_q[31:0];

	// a failed parse never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q[32]) |-> (res_q[31:0] == '0))
		else $error("address not zero on failed parse");

	// the end byte puts the parser back to its start
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_end) |=> (phase_q == PH_START && parts_done_q == '0 && res_valid_q))
		else $error("end byte did not restart parser");

	// once whitespace closed the parse the held result stays put
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !(pop && is_end)) |=> $stable(held_q))
		else $error("held result changed after parse finished");

endmodule

`default_nettype wire
